// ----- src/sdpsd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpsd_pkg: shared types and constants
// Widths, configuration register codes and item types shared by the step/dir
// decoder modules.
// ----------------------------------------------------------------------------
package sdpsd_pkg;

  localparam int COUNT_WIDTH        = 48;
  localparam int RESULT_QUEUE_DEPTH = 4;

  localparam int OUT_W      = 48;
  localparam int RATE_W     = 40;
  localparam int SPM_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = RATE_W;

  // Common width for truncating or zero-extending counters to result width.
  localparam int WIDE_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;
  // Dividend width: covers rate * 25600 (55 bits) and |pos| * 25600 + spm/2.
  localparam int DIV_W  = (COUNT_WIDTH + 16 > 55) ? COUNT_WIDTH + 16 : 55;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UNIT_MM     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = 2'd2;

  localparam logic [RATE_W-1:0] RATE_RESET  = 40'd1000000;
  localparam logic [SPM_W-1:0]  SPM_DEFAULT = 32'd25600;   // 100.0 in q8
  localparam logic [SPM_W-1:0]  SCALE_STEPS = 32'd256;     // 1.0 in q8

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  typedef logic [OUT_W-1:0]       out_t;

  typedef struct packed {
    logic [RATE_W-1:0] sample_rate_hz;
    logic              unit_mm;
    logic [SPM_W-1:0]  steps_per_mm_q8;
  } cfg_t;

  // One pending result, as captured at a rising step edge.
  typedef struct packed {
    cnt_t start_sample;
    cnt_t end_sample;
    cnt_t position;
  } edge_t;

  // Truncate or zero-extend a counter value to the result width.
  function automatic out_t fit_out(cnt_t x);
    logic [WIDE_W-1:0] w;
    w = WIDE_W'(x);
    return w[OUT_W-1:0];
  endfunction

endpackage

// ----- src/sdpsd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpsd_front: sample counter and edge classifier
// Counts pin samples, detects rising step edges, tracks position and pushes
// one entry per reportable edge into the result queue.
// ----------------------------------------------------------------------------
module sdpsd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sdpsd_pkg::cfg_t    cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               step_level_i,
  input  logic               dir_level_i,
  input  logic               q_full_i,
  output logic               push_o,
  output sdpsd_pkg::edge_t   push_data_o
);
  import sdpsd_pkg::*;

  cnt_t sample_count_q, sample_count_d;
  cnt_t last_edge_q, last_edge_d;
  cnt_t position_q, position_d;
  logic last_step_q, last_step_d;
  logic edge_seen_q, edge_seen_d;
  logic accept, rising;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign rising     = step_level_i && !last_step_q;

  assign push_o = accept && rising && edge_seen_q && (cfg_i.sample_rate_hz != '0);
  assign push_data_o = '{start_sample: last_edge_q,
                         end_sample:   sample_count_q,
                         position:     position_q};

  always_comb begin
    sample_count_d = sample_count_q;
    last_edge_d    = last_edge_q;
    position_d     = position_q;
    last_step_d    = last_step_q;
    edge_seen_d    = edge_seen_q;
    if (accept) begin
      sample_count_d = sample_count_q + cnt_t'(1);
      last_step_d    = step_level_i;
      if (rising) begin
        position_d  = dir_level_i ? position_q + cnt_t'(1) : position_q - cnt_t'(1);
        last_edge_d = sample_count_q;
        edge_seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_count_q <= '0;
      last_edge_q    <= '0;
      position_q     <= '0;
      last_step_q    <= 1'b1;  // high pin in the first sample is no edge
      edge_seen_q    <= 1'b0;
    end else begin
      sample_count_q <= sample_count_d;
      last_edge_q    <= last_edge_d;
      position_q     <= position_d;
      last_step_q    <= last_step_d;
      edge_seen_q    <= edge_seen_d;
    end
  end

endmodule

// ----- src/sdpsd_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpsd_queue: edge result queue
// Small FIFO of captured edges between the classifier and the divider unit.
// ----------------------------------------------------------------------------
module sdpsd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  sdpsd_pkg::edge_t push_data_i,
  output logic             full_o,
  output logic             pop_valid_o,
  input  logic             pop_i,
  output sdpsd_pkg::edge_t pop_data_o
);
  import sdpsd_pkg::*;

  localparam int PTR_W = (RESULT_QUEUE_DEPTH > 1) ? $clog2(RESULT_QUEUE_DEPTH) : 1;
  localparam int FILL_W = $clog2(RESULT_QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(RESULT_QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(RESULT_QUEUE_DEPTH);

  edge_t             entry_q [RESULT_QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              do_push, do_pop;

  assign full_o      = (fill_q == FILL_MAX);
  assign pop_valid_o = (fill_q != '0);
  assign pop_data_o  = entry_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    case ({do_push, do_pop})
      2'b10:   fill_d = fill_q + FILL_W'(1);
      2'b01:   fill_d = fill_q - FILL_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- src/sdpsd_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdpsd_back: speed and millimeter position unit
// Pops one captured edge, forms the speed divisor with two 32x32 partial
// products, runs two bit-serial restoring dividers side by side, rounds,
// saturates and loads the output register.
// ----------------------------------------------------------------------------
module sdpsd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sdpsd_pkg::cfg_t          cfg_i,
  input  logic                     pop_valid_i,
  input  sdpsd_pkg::edge_t         pop_data_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [sdpsd_pkg::OUT_W-1:0]        start_sample_o,
  output logic [sdpsd_pkg::OUT_W-1:0]        end_sample_o,
  output logic [sdpsd_pkg::OUT_W-1:0]        speed_centi_o,
  output logic signed [sdpsd_pkg::OUT_W-1:0] position_steps_o,
  output logic signed [sdpsd_pkg::OUT_W-1:0] position_centi_mm_o
);
  import sdpsd_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_MLO  = 6'b000010,
    S_MHI  = 6'b000100,
    S_DIV  = 6'b001000,
    S_RND  = 6'b010000,
    S_OUT  = 6'b100000
  } state_e;

  localparam int CNT_W = $clog2(DIV_W);
  localparam logic [DIV_W-1:0] SAT_MAX   = DIV_W'({OUT_W{1'b1}});
  localparam logic [DIV_W-1:0] POS_LIMIT = DIV_W'({(OUT_W-1){1'b1}});

  // x * 25600 as shifts and adds (25600 = 2^14 + 2^13 + 2^10)
  function automatic logic [DIV_W-1:0] times_centi_q8(logic [DIV_W-1:0] x);
    return (x << 14) + (x << 13) + (x << 10);
  endfunction

  state_e state_q, state_d;

  cnt_t              start_q, end_q, pos_q;
  logic [63:0]       delta_q;
  logic [SPM_W-1:0]  scale_q, spm_q;
  logic [63:0]       plo_q;
  logic [63:0]       d_q;
  logic              ovf_q, neg_q;
  logic [DIV_W-1:0]  num_s_q, quo_s_q, num_c_q, quo_c_q;
  logic [63:0]       rem_s_q;
  logic [SPM_W-1:0]  rem_c_q;
  logic [CNT_W-1:0]  cnt_q;
  out_t              speed_q, centi_q;

  logic              out_valid_q;
  out_t              start_o_q, end_o_q, speed_o_q, pos_o_q, centi_o_q;

  logic [SPM_W-1:0]  eff_spm;
  cnt_t              diff, mag;
  logic [95:0]       prod;
  logic [64:0]       rem_s_t, rem_s_n;
  logic [SPM_W:0]    rem_c_t, rem_c_n;
  logic              ge_s, ge_c, round_s;
  logic [DIV_W:0]    q_r;
  logic [DIV_W-1:0]  limit, total;
  out_t              speed_n, tot48, centi_n;
  logic              load_out;

  assign eff_spm = (cfg_i.steps_per_mm_q8 == '0) ? SPM_DEFAULT : cfg_i.steps_per_mm_q8;
  assign diff    = pop_data_i.end_sample - pop_data_i.start_sample;
  assign mag     = pos_q[COUNT_WIDTH-1] ? cnt_t'(-pos_q) : pos_q;
  assign prod    = {32'b0, plo_q} + {64'(delta_q[63:32]) * 64'(scale_q), 32'b0};

  // one restoring step per cycle in each divider
  assign rem_s_t = {rem_s_q, num_s_q[DIV_W-1]};
  assign ge_s    = (rem_s_t >= {1'b0, d_q});
  assign rem_s_n = ge_s ? rem_s_t - {1'b0, d_q} : rem_s_t;
  assign rem_c_t = {rem_c_q, num_c_q[DIV_W-1]};
  assign ge_c    = (rem_c_t >= {1'b0, spm_q});
  assign rem_c_n = ge_c ? rem_c_t - {1'b0, spm_q} : rem_c_t;

  // speed: round half up, then zero divisor / overflow / saturation
  assign round_s = ({rem_s_q, 1'b0} >= {1'b0, d_q});
  assign q_r     = {1'b0, quo_s_q} + (DIV_W + 1)'(round_s);
  always_comb begin
    if (ovf_q) begin
      speed_n = '0;
    end else if (d_q == '0) begin
      speed_n = '1;
    end else if (q_r > {1'b0, SAT_MAX}) begin
      speed_n = '1;
    end else begin
      speed_n = q_r[OUT_W-1:0];
    end
  end

  // millimeter position: clamp magnitude, then restore the sign
  assign limit   = neg_q ? POS_LIMIT + DIV_W'(1) : POS_LIMIT;
  assign total   = (quo_c_q > limit) ? limit : quo_c_q;
  assign tot48   = total[OUT_W-1:0];
  assign centi_n = neg_q ? out_t'(-tot48) : tot48;

  assign pop_o    = (state_q == S_IDLE) && pop_valid_i;
  assign load_out = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (pop_valid_i) state_d = S_MLO;
      S_MLO:   state_d = S_MHI;
      S_MHI:   state_d = S_DIV;
      S_DIV:   if (cnt_q == '0) state_d = S_RND;
      S_RND:   state_d = S_OUT;
      S_OUT:   if (load_out) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (pop_valid_i) begin
          start_q <= pop_data_i.start_sample;
          end_q   <= pop_data_i.end_sample;
          pos_q   <= pop_data_i.position;
          delta_q <= 64'(diff);
          scale_q <= cfg_i.unit_mm ? eff_spm : SCALE_STEPS;
          spm_q   <= eff_spm;
          num_s_q <= times_centi_q8(DIV_W'(cfg_i.sample_rate_hz));
        end
      end
      S_MLO: begin
        plo_q   <= 64'(delta_q[31:0]) * 64'(scale_q);
        neg_q   <= pos_q[COUNT_WIDTH-1];
        num_c_q <= times_centi_q8(DIV_W'(mag)) + DIV_W'(spm_q >> 1);
      end
      S_MHI: begin
        d_q     <= prod[63:0];
        ovf_q   <= |prod[95:64];
        rem_s_q <= '0;
        rem_c_q <= '0;
        quo_s_q <= '0;
        quo_c_q <= '0;
        cnt_q   <= CNT_W'(DIV_W - 1);
      end
      S_DIV: begin
        rem_s_q <= rem_s_n[63:0];
        rem_c_q <= rem_c_n[SPM_W-1:0];
        quo_s_q <= {quo_s_q[DIV_W-2:0], ge_s};
        quo_c_q <= {quo_c_q[DIV_W-2:0], ge_c};
        num_s_q <= num_s_q << 1;
        num_c_q <= num_c_q << 1;
        cnt_q   <= cnt_q - CNT_W'(1);
      end
      S_RND: begin
        speed_q <= speed_n;
        centi_q <= centi_n;
      end
      S_OUT: begin
        if (load_out) begin
          start_o_q <= fit_out(start_q);
          end_o_q   <= fit_out(end_q);
          speed_o_q <= speed_q;
          pos_o_q   <= fit_out(pos_q);
          centi_o_q <= centi_q;
        end
      end
      default: begin
        cnt_q <= cnt_q;
      end
    endcase
  end

  assign out_valid_o         = out_valid_q;
  assign start_sample_o      = start_o_q;
  assign end_sample_o        = end_o_q;
  assign speed_centi_o       = speed_o_q;
  assign position_steps_o    = $signed(pos_o_q);
  assign position_centi_mm_o = $signed(centi_o_q);

endmodule

// ----- src/step_dir_position_speed_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_dir_position_speed_decoder: step/dir position and speed decoder
// Decodes a sampled step/dir pin stream into per-edge speed and position.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one step/dir pin sample per
//    transfer, one transfer per clock while the result queue has room.
//  - Output channel (out_valid_o/out_ready_i): one transfer per rising step edge
//    that follows an earlier edge, with a nonzero sample rate, carrying both
//    edge sample numbers, speed x100, position in steps and in hundredths of a mm.
//  - Config channel (cfg_valid_i/cfg_ready_o): always ready; write only while
//    the block is idle. Indexes past the register list are ignored.
//  - Sequence: each reportable edge sample is pushed into the queue; the divider
//    unit then works through it in order: pop, the two partial products, 64
//    restoring divider steps, round, output load.
//  - Throughput: samples flow at one per clock while the queue has room; edges
//    wait in a 4-entry queue, and the divider unit pops one only when idle.
//  - Reset: counters, position and edge tracking clear, the step pin is
//    taken as high, and the registers return to 1 MHz, steps/s, 100 steps/mm.
//  - Receiver stall: the output register holds its result; the divider unit
//    then parks finished work, the queue fills, and in_ready_o drops when
//    the queue is full.
// ----------------------------------------------------------------------------
module step_dir_position_speed_decoder (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // configuration
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [sdpsd_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sdpsd_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // pin samples
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  step_level_i,
  input  logic                                  dir_level_i,
  // results
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [sdpsd_pkg::OUT_W-1:0]           start_sample_o,
  output logic [sdpsd_pkg::OUT_W-1:0]           end_sample_o,
  output logic [sdpsd_pkg::OUT_W-1:0]           speed_centi_o,
  output logic signed [sdpsd_pkg::OUT_W-1:0]    position_steps_o,
  output logic signed [sdpsd_pkg::OUT_W-1:0]    position_centi_mm_o
);
  import sdpsd_pkg::*;

  cfg_t  cfg_q;
  logic  q_full, push, pop_valid, pop;
  edge_t push_data, pop_data;

  // Configuration registers; the config port never stalls.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sample_rate_hz  <= RATE_RESET;
      cfg_q.unit_mm         <= 1'b0;
      cfg_q.steps_per_mm_q8 <= SPM_DEFAULT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_RATE:  cfg_q.sample_rate_hz  <= cfg_data_i[RATE_W-1:0];
        CFG_UNIT_MM:      cfg_q.unit_mm         <= cfg_data_i[0];
        CFG_STEPS_PER_MM: cfg_q.steps_per_mm_q8 <= cfg_data_i[SPM_W-1:0];
        default:          cfg_q                 <= cfg_q;
      endcase
    end
  end

  // Front: sample counting, edge detection, position tracking.
  sdpsd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .step_level_i (step_level_i),
    .dir_level_i  (dir_level_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_data_o  (push_data)
  );

  // Queue of edges waiting for the divider unit.
  sdpsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .pop_valid_o (pop_valid),
    .pop_i       (pop),
    .pop_data_o  (pop_data)
  );

  // Back: speed and mm position arithmetic plus output register.
  sdpsd_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_i               (cfg_q),
    .pop_valid_i         (pop_valid),
    .pop_data_i          (pop_data),
    .pop_o               (pop),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .start_sample_o      (start_sample_o),
    .end_sample_o        (end_sample_o),
    .speed_centi_o       (speed_centi_o),
    .position_steps_o    (position_steps_o),
    .position_centi_mm_o (position_centi_mm_o)
  );

endmodule

// ----- tb/step_dir_position_speed_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_dir_position_speed_decoder_tb: self-checking bench for the decoder
// Feeds step/dir pin samples over the input channel and checks every result
// transfer against a cycle-free predictor of the decoder. The run opens with
// a short table of hand-picked samples and register writes, then plays twelve
// segments of random pulse trains. Each segment runs under its own register
// setting, and the idle pattern on both channels changes as the run goes on.
// ----------------------------------------------------------------------------
module step_dir_position_speed_decoder_tb;
  import sdpsd_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int SETTLE_CYCLES = 100;     // settling wait after the last expected result
  localparam int SEGMENTS      = 12;
  localparam int SEG_ITEMS     = 128;
  localparam int DENSE_SEG     = 9;       // edge-heavy segment run under the long stall
  localparam int HOLD_CYCLES   = 800;
  localparam int END_LIMIT     = 50000;

  // Index 3 has no register behind it; writes to it must be dropped.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [63:0] CENTI_Q8 = 64'd25600;   // 100.0 in q8
  localparam logic [63:0] OUT_MAX  = (64'd1 << OUT_W) - 64'd1;
  localparam logic [63:0] POS_MAX  = (64'd1 << (OUT_W - 1)) - 64'd1;

  typedef struct packed {
    out_t start_s;
    out_t end_s;
    out_t speed;
    out_t pos_steps;
    out_t pos_cmm;
  } edge_report_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_WRITE} row_kind_e;
  // Where the expectation of a sample comes from: the predictor, a typed-in
  // "no result", or a typed-in report.
  typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_GIVEN} exp_src_e;

  typedef struct packed {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    idx;
    logic [CFG_DATA_W-1:0]   data;
    logic                    step;
    logic                    dir;
    exp_src_e                src;
    edge_report_t            rep;
  } plan_row_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                     clk_i        = 1'b0;
  logic                     rst_ni       = 1'b0;
  logic                     cfg_valid_i  = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_W-1:0]     cfg_index_i  = '0;
  logic [CFG_DATA_W-1:0]    cfg_data_i   = '0;
  logic                     in_valid_i   = 1'b0;
  logic                     in_ready_o;
  logic                     step_level_i = 1'b0;
  logic                     dir_level_i  = 1'b0;
  logic                     out_valid_o;
  logic                     out_ready_i  = 1'b0;
  logic [OUT_W-1:0]         start_sample_o;
  logic [OUT_W-1:0]         end_sample_o;
  logic [OUT_W-1:0]         speed_centi_o;
  logic signed [OUT_W-1:0]  position_steps_o;
  logic signed [OUT_W-1:0]  position_centi_mm_o;

  // Expectation source travels with the sample so the monitor sees it at the
  // same edge as the transfer.
  exp_src_e                 smp_src      = EXP_MODEL;
  edge_report_t             smp_given    = '0;

  // --------------------------------------------------------------------------
  // Predictor state: register shadow and decoder state, at reset values
  // --------------------------------------------------------------------------
  logic [RATE_W-1:0]        rate_hz      = RATE_RESET;
  logic                     unit_is_mm   = 1'b0;
  logic [SPM_W-1:0]         spm_q8       = SPM_DEFAULT;
  cnt_t                     sample_no    = '0;
  logic                     step_prev    = 1'b1;   // pin taken as high at reset
  cnt_t                     ref_edge_no  = '0;
  logic                     ref_valid    = 1'b0;
  cnt_t                     position     = '0;

  edge_report_t             edge_reports_due[$];
  int unsigned              mismatches   = 0;

  int                       send_idle_pct = 7;
  int                       recv_idle_pct = 50;
  int                       hold_reqs     = 0;
  int                       run_left      = 0;
  logic                     run_level     = 1'b0;

  // --------------------------------------------------------------------------
  // Directed table. Typed-in reports are the easy ones: default rate gives
  // 100 * 1e6 / interval, and spm of 1 with max rate saturates the speed.
  // --------------------------------------------------------------------------
  localparam int PLAN_LEN = 32;
  plan_row_t plan [PLAN_LEN] = '{
    // pin high in the first sample is not an edge
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b0, EXP_MODEL, '0},
    // first edge only sets the reference
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_NONE,  '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, EXP_GIVEN,
      '{48'd2, 48'd4, 48'd50000000, 48'd1, 48'd1}},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, EXP_GIVEN,
      '{48'd4, 48'd7, 48'd33333333, 48'd0, 48'd0}},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b0, EXP_MODEL, '0},
    // position -1 in both units
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_GIVEN,
      '{48'd7, 48'd9, 48'd50000000, '1, '1}},
    // zero rate: edge still moves position and reference, no report
    '{ROW_WRITE,  CFG_SAMPLE_RATE,  40'd0,            1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_NONE,  '0},
    // max rate, mm mode, tiniest spm: speed saturates
    '{ROW_WRITE,  CFG_SAMPLE_RATE,  40'hFF_FFFF_FFFF, 1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_WRITE,  CFG_UNIT_MM,      40'd1,            1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_WRITE,  CFG_STEPS_PER_MM, 40'd1,            1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_GIVEN,
      '{48'd11, 48'd13, '1, 48'd1, 48'd25600}},
    // zero spm falls back to 100.0; speed lands on a rounding half
    '{ROW_WRITE,  CFG_STEPS_PER_MM, 40'd0,            1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, EXP_MODEL, '0},
    // max spm with minimum rate; write to the unused index is dropped
    '{ROW_WRITE,  CFG_STEPS_PER_MM, 40'hFFFF_FFFF,    1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_WRITE,  CFG_SAMPLE_RATE,  40'd1,            1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_WRITE,  CFG_UNUSED,       40'hFF_FFFF_FFFF, 1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_MODEL, '0},
    // back to reset values; a held-high pin is not a new edge
    '{ROW_WRITE,  CFG_UNIT_MM,      40'd0,            1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_WRITE,  CFG_STEPS_PER_MM, 40'd25600,        1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_WRITE,  CFG_SAMPLE_RATE,  40'd1000000,      1'b0, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b0, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b0, 1'b1, EXP_MODEL, '0},
    '{ROW_SAMPLE, '0, '0, 1'b1, 1'b1, EXP_MODEL, '0}
  };

  step_dir_position_speed_decoder u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .step_level_i        (step_level_i),
    .dir_level_i         (dir_level_i),
    .out_valid_o         (out_valid_o),
    .out_ready_i         (out_ready_i),
    .start_sample_o      (start_sample_o),
    .end_sample_o        (end_sample_o),
    .speed_centi_o       (speed_centi_o),
    .position_steps_o    (position_steps_o),
    .position_centi_mm_o (position_centi_mm_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] spm_eff();
    return (spm_q8 == '0) ? 64'(SPM_DEFAULT) : 64'(spm_q8);
  endfunction

  // 100 * rate / (interval * scale), scale in q8; rounded half up, saturated
  function automatic out_t speed_centi_of(cnt_t interval);
    logic [63:0]  num;
    logic [63:0]  scale;
    logic [63:0]  q;
    logic [63:0]  r;
    logic [127:0] d;
    num   = 64'(rate_hz) * CENTI_Q8;
    scale = unit_is_mm ? spm_eff() : 64'(SCALE_STEPS);
    d     = 128'(interval) * 128'(scale);
    if (d[127:64] != '0) return '0;
    if (d == '0) return OUT_MAX[OUT_W-1:0];   // exact counter wrap
    q = num / d[63:0];
    r = num % d[63:0];
    if (r >= d[63:0] - r) q++;
    if (q > OUT_MAX) q = OUT_MAX;
    return q[OUT_W-1:0];
  endfunction

  // 100 * pos / spm, rounded half away from zero, saturated to signed 48 bit
  function automatic out_t centi_mm_of(cnt_t pos);
    logic signed [63:0] sx;
    logic [63:0]        spm;
    logic [63:0]        mag;
    logic [63:0]        lim;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        total;
    logic               neg;
    sx  = 64'($signed(pos));
    neg = pos[COUNT_WIDTH-1];
    spm = spm_eff();
    mag = neg ? 64'(-sx) : 64'(sx);
    lim = neg ? POS_MAX + 64'd1 : POS_MAX;
    q   = mag / spm;
    r   = mag % spm;
    if (q > lim / CENTI_Q8) begin
      total = lim;
    end else begin
      total = q * CENTI_Q8 + (r * CENTI_Q8 + spm / 64'd2) / spm;
      if (total > lim) total = lim;
    end
    total = neg ? 64'd0 - total : total;
    return total[OUT_W-1:0];
  endfunction

  // Advances the decoder by one pin sample; returns 1 with a report when the
  // sample is a rising edge that closes an interval.
  function automatic logic decode_pin_sample(input logic stp, input logic dr,
                                             output edge_report_t rep);
    cnt_t n;
    logic emit;
    n         = sample_no;
    emit      = 1'b0;
    rep       = '0;
    sample_no = n + 1'b1;
    if (stp && !step_prev) begin
      if (ref_valid && rate_hz != '0) begin
        rep.start_s   = out_t'(ref_edge_no);
        rep.end_s     = out_t'(n);
        rep.speed     = speed_centi_of(n - ref_edge_no);
        rep.pos_steps = out_t'(position);
        rep.pos_cmm   = centi_mm_of(position);
        emit          = 1'b1;
      end
      position    = dr ? position + 1'b1 : position - 1'b1;
      ref_edge_no = n;
      ref_valid   = 1'b1;
    end
    step_prev = stp;
    return emit;
  endfunction

  function automatic void check_field(string name, out_t want, out_t got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
      mismatches++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: register shadow, expectations on input transfers, checks on
  // output transfers. Everything here samples pre-edge values.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    edge_report_t rep;
    edge_report_t want;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SAMPLE_RATE:  rate_hz    = cfg_data_i[RATE_W-1:0];
          CFG_UNIT_MM:      unit_is_mm = cfg_data_i[0];
          CFG_STEPS_PER_MM: spm_q8     = cfg_data_i[SPM_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_o) begin
        // predictor always runs so its state tracks typed-in rows too
        if (decode_pin_sample(step_level_i, dir_level_i, rep) && smp_src == EXP_MODEL)
          edge_reports_due.push_back(rep);
        if (smp_src == EXP_GIVEN) edge_reports_due.push_back(smp_given);
      end
      if (out_valid_o && out_ready_i) begin
        if (edge_reports_due.size() == 0) begin
          $error("unexpected result: start 0x%h end 0x%h", start_sample_o, end_sample_o);
          mismatches++;
        end else begin
          want = edge_reports_due.pop_front();
          check_field("start_sample",      want.start_s,   start_sample_o);
          check_field("end_sample",        want.end_s,     end_sample_o);
          check_field("speed_centi",       want.speed,     speed_centi_o);
          check_field("position_steps",    want.pos_steps, position_steps_o);
          check_field("position_centi_mm", want.pos_cmm,   position_centi_mm_o);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result receiver: random ready, plus a long hold-off on request that it
  // counts itself
  // --------------------------------------------------------------------------
  initial begin
    int holds_done;
    holds_done = 0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != holds_done) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        holds_done++;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus tasks; each is entered right after a rising edge
  // --------------------------------------------------------------------------

  // Offers one sample and returns at the edge that transfers it. Valid is
  // held across back-to-back samples.
  task automatic send_sample(input logic stp, input logic dr, input exp_src_e src,
                             input edge_report_t given);
    cfg_valid_i <= 1'b0;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    step_level_i <= stp;
    dir_level_i  <= dr;
    smp_src      <= src;
    smp_given    <= given;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Back-to-back writes keep cfg_valid_i high; the next sample or drain drops it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  // Sender pause: all reports in, then room for an edge that makes no report
  // (first edge, zero rate) to clear the divider before a register write.
  task automatic wait_idle();
    in_valid_i  <= 1'b0;
    cfg_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (edge_reports_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Step pin as a pulse train of random run lengths: mostly short runs, some
  // medium, a few long intervals. Outside the dense segment a sample now and
  // then is a random level instead.
  function automatic logic next_step_level(input logic dense);
    int unsigned pick;
    if (run_left == 0) begin
      run_level = !run_level;
      pick      = $urandom_range(99);
      if (dense)          run_left = $urandom_range(1, 2);
      else if (pick < 80) run_left = $urandom_range(1, 3);
      else if (pick < 97) run_left = $urandom_range(4, 30);
      else                run_left = $urandom_range(31, 300);
    end
    run_left--;
    if (!dense && $urandom_range(99) < 10) return 1'($urandom_range(1));
    return run_level;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    plan_row_t          row;
    logic               prev_write;
    logic [RATE_W-1:0]  rate;
    logic [SPM_W-1:0]   spm;
    int unsigned        pick;

    prev_write = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: sender 7%, receiver 50% idle
    foreach (plan[i]) begin
      row = plan[i];
      if (row.kind == ROW_WRITE) begin
        if (!prev_write) wait_idle();
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.step, row.dir, row.src, row.rep);
      end
      prev_write = (row.kind == ROW_WRITE);
    end

    // random part: one register setting per segment
    for (int s = 0; s < SEGMENTS; s++) begin
      wait_idle();
      if (s < 4) begin
        send_idle_pct =  7;
        recv_idle_pct <= 50;
      end else if (s < 8) begin
        send_idle_pct = 50;
        recv_idle_pct <= 7;
      end else begin
        send_idle_pct =  0;
        recv_idle_pct <= 0;
      end

      pick = $urandom_range(9);
      case (pick)
        0:       rate = '0;
        1:       rate = RATE_W'(1);
        2:       rate = '1;
        3, 4:    rate = RATE_RESET;
        5, 6:    rate = {8'($urandom_range(255)), 32'($urandom)};
        default: rate = RATE_W'($urandom_range(1, 50000000));
      endcase
      if (s == DENSE_SEG) rate = RATE_RESET;   // results needed to fill the queue

      pick = $urandom_range(9);
      case (pick)
        0:       spm = '0;
        1:       spm = SPM_W'(1);
        2:       spm = '1;
        3:       spm = SPM_DEFAULT;
        4, 5, 6: spm = SPM_W'($urandom_range(1, 1000000));
        default: spm = SPM_W'($urandom);
      endcase

      write_reg(CFG_SAMPLE_RATE, CFG_DATA_W'(rate));
      write_reg(CFG_UNIT_MM, CFG_DATA_W'($urandom_range(1)));
      write_reg(CFG_STEPS_PER_MM, CFG_DATA_W'(spm));

      // long receiver stall while edges keep coming: queue fills, input stalls
      if (s == DENSE_SEG) hold_reqs <= hold_reqs + 1;

      for (int i = 0; i < SEG_ITEMS; i++)
        send_sample(next_step_level(s == DENSE_SEG), 1'($urandom_range(1)), EXP_MODEL, '0);
    end

    // drain, then give late or stray results time to show up
    in_valid_i <= 1'b0;
    for (int k = 0; k < END_LIMIT && edge_reports_due.size() != 0; k++) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (edge_reports_due.size() != 0) begin
      $error("%0d expected results never arrived", edge_reports_due.size());
      mismatches++;
    end

    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #(CLK_PERIOD * 1000000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
src/sdpsd_pkg.sv
src/sdpsd_front.sv
src/sdpsd_queue.sv
src/sdpsd_back.sv
src/step_dir_position_speed_decoder.sv
tb/step_dir_position_speed_decoder_tb.sv
